/* design/zip_stored_entry_extractor_unit_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ZIP_STORED_ENTRY_EXTRACTOR_UNIT_MACROS_SVH
`define ZIP_STORED_ENTRY_EXTRACTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ZSEE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ZSEE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/zsee_pkg.sv */
// types, constants and helper functions of the stored zip entry extractor
// no dependencies
package zsee_pkg;

    localparam int CNT_W      = 23;
    localparam int HDR_LEN    = 30;
    localparam int HDR_AW     = 5;
    localparam int NAME_LEN   = 11;
    localparam int NAME_AW    = 4;
    localparam int PAYLOAD_W  = 23;
    localparam int EXTRA_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [31:0]          LFH_SIGNATURE     = 32'h0403_4b50;
    localparam logic [15:0]          DESC_FLAG_MASK    = 16'h0008;
    localparam logic [15:0]          NAME_LEN_EXPECTED = 16'd11;
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST   = 23'd4194304;
    localparam logic [EXTRA_W-1:0]   MAX_EXTRA_RST     = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXTRA   = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [2:0] {
        ERR_SIGNATURE = 3'd0,
        ERR_METHOD    = 3'd1,
        ERR_NAME_LEN  = 3'd2,
        ERR_EXTRA     = 3'd3,
        ERR_SIZE      = 3'd4,
        ERR_NAME      = 3'd5,
        ERR_TRUNCATED = 3'd6
    } t_err;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_EXTRA   = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       last;
        t_err       err_code;
    } t_word;

    // expected entry name "preview.png"
    function automatic logic [7:0] name_char(input logic [NAME_AW-1:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                4'd0:    c = 8'h70;
                4'd1:    c = 8'h72;
                4'd2:    c = 8'h65;
                4'd3:    c = 8'h76;
                4'd4:    c = 8'h69;
                4'd5:    c = 8'h65;
                4'd6:    c = 8'h77;
                4'd7:    c = 8'h2e;
                4'd8:    c = 8'h70;
                4'd9:    c = 8'h6e;
                4'd10:   c = 8'h67;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* design/zsee_front.sv */
// front end: config registers, header store and parse state machine
// depends on zsee_pkg
module zsee_front import zsee_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_file,
    input  logic                 i_end_of_file,
    output logic                 o_push,
    output t_word                o_word
);

    logic [PAYLOAD_W-1:0] r_max_payload;
    logic [EXTRA_W-1:0]   r_max_extra;
    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_name_ok, n_name_ok;
    logic [7:0]           r_hdr [HDR_LEN];

    t_phase           ph;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic             name_ok;
    logic             hdr_we;
    logic [31:0]      w_sig;
    logic [15:0]      w_method;
    logic [15:0]      w_name_len;
    logic [15:0]      w_extra_new;
    logic [15:0]      w_extra;
    logic [31:0]      w_csize;
    logic [31:0]      w_usize;
    logic             char_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_max_extra   <= MAX_EXTRA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[PAYLOAD_W-1:0];
                CFG_MAX_EXTRA:   r_max_extra   <= i_cfg_data[EXTRA_W-1:0];
                default: ;
            endcase
        end
    end

    assign ph      = i_start_of_file ? PH_HEADER : r_phase;
    assign cnt     = i_start_of_file ? '0 : r_cnt;
    assign name_ok = i_start_of_file ? 1'b1 : r_name_ok;
    assign cnt_inc = cnt + CNT_W'(1);

    assign w_sig       = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_method    = {r_hdr[9], r_hdr[8]};
    assign w_name_len  = {r_hdr[27], r_hdr[26]};
    assign w_extra_new = {i_data_byte, r_hdr[28]};
    assign w_extra     = {r_hdr[29], r_hdr[28]};
    assign w_csize     = {r_hdr[21], r_hdr[20], r_hdr[19], r_hdr[18]};
    assign w_usize     = {r_hdr[25], r_hdr[24], r_hdr[23], r_hdr[22]};
    assign char_ok     = (i_data_byte == name_char(cnt[NAME_AW-1:0]));

    assign hdr_we = i_accept && !i_end_of_file && (ph == PH_HEADER)
                    && (cnt < CNT_W'(HDR_LEN));

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[cnt[HDR_AW-1:0]] <= i_data_byte;
        end
    end

    always_comb begin
        n_phase   = ph;
        n_cnt     = cnt;
        n_name_ok = name_ok;
        o_push    = 1'b0;
        o_word    = '{kind: KIND_DATA, payload_byte: 8'h00, last: 1'b0,
                      err_code: ERR_SIGNATURE};
        if (i_end_of_file) begin
            if (ph != PH_DONE) begin
                o_push          = 1'b1;
                o_word.kind     = KIND_ERROR;
                o_word.last     = 1'b1;
                o_word.err_code = ERR_TRUNCATED;
                n_phase         = PH_DONE;
                n_cnt           = '0;
            end
        end else begin
            unique case (ph)
                PH_HEADER: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= CNT_W'(HDR_LEN)) begin
                        n_cnt           = '0;
                        n_phase         = PH_DONE;
                        o_push          = 1'b1;
                        o_word.kind     = KIND_ERROR;
                        o_word.last     = 1'b1;
                        priority if (w_sig != LFH_SIGNATURE) begin
                            o_word.err_code = ERR_SIGNATURE;
                        end else if ((r_hdr[6] & DESC_FLAG_MASK[7:0]) != 8'h00
                                     || w_method != 16'h0000) begin
                            o_word.err_code = ERR_METHOD;
                        end else if (w_name_len != NAME_LEN_EXPECTED) begin
                            o_word.err_code = ERR_NAME_LEN;
                        end else if (w_extra_new > r_max_extra) begin
                            o_word.err_code = ERR_EXTRA;
                        end else if (w_csize != w_usize || w_csize == 32'h0
                                     || w_csize > 32'(r_max_payload)) begin
                            o_word.err_code = ERR_SIZE;
                        end else begin
                            o_push  = 1'b0;
                            o_word.kind = KIND_DATA;
                            o_word.last = 1'b0;
                            n_phase = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    n_cnt     = cnt_inc;
                    n_name_ok = name_ok && char_ok;
                    if (cnt_inc >= CNT_W'(NAME_LEN)) begin
                        n_cnt = '0;
                        if (!(name_ok && char_ok)) begin
                            o_push          = 1'b1;
                            o_word.kind     = KIND_ERROR;
                            o_word.last     = 1'b1;
                            o_word.err_code = ERR_NAME;
                            n_phase         = PH_DONE;
                        end else if (w_extra == 16'h0000) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_EXTRA;
                        end
                    end
                end
                PH_EXTRA: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc == CNT_W'(w_extra)) begin
                        n_cnt   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_cnt               = cnt_inc;
                    o_push              = 1'b1;
                    o_word.payload_byte = i_data_byte;
                    if (cnt_inc == CNT_W'(w_csize)) begin
                        o_word.last = 1'b1;
                        n_phase     = PH_DONE;
                        n_cnt       = '0;
                    end
                end
                default: ;
            endcase
        end
        o_push = o_push && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_cnt     <= '0;
            r_name_ok <= 1'b1;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_name_ok <= n_name_ok;
        end
    end

endmodule

/* design/zsee_queue.sv */
// small result queue between the parser and the output stage
// depends on zsee_pkg
module zsee_queue import zsee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_not_empty,
    output t_word o_word
);

    t_word                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count, n_count;

    assign o_full      = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_word      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

/* design/zsee_back.sv */
// back end: output register that hands result words to the consumer
// depends on zsee_pkg
module zsee_back import zsee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_not_empty,
    input  t_word i_q_word,
    output logic  o_pop,
    input  logic  i_stall,
    output logic  o_valid,
    output t_word o_word
);

    logic  r_valid;
    t_word r_word;

    assign o_pop   = i_q_not_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_q_word;
        end
    end

endmodule

/* design/zip_stored_entry_extractor_unit.sv */
// Stored zip entry extractor: parses the first local file header of a byte
// stream, checks it, matches the name "preview.png" and streams out the stored
// payload bytes, or one error word. One byte is taken per clock while the
// result queue is not full; the only per-byte work is the phase counter step
// and its compare, so a new byte can enter every cycle. A four-word queue
// sits between the parser and the output register; o_in_stall rises only
// when that queue is full.
// depends on zsee_pkg, zsee_front, zsee_queue, zsee_back
module zip_stored_entry_extractor_unit import zsee_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_of_file,
    input  logic                  i_end_of_file,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_kind,
    output logic [7:0]            o_payload_byte,
    output logic                  o_last,
    output logic [2:0]            o_error_code
);

    logic  accept;
    logic  push;
    t_word front_word;
    logic  q_full;
    logic  q_not_empty;
    t_word q_word;
    logic  pop;
    t_word out_word;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    zsee_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_end_of_file   (i_end_of_file),
        .o_push          (push),
        .o_word          (front_word)
    );

    zsee_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_word      (front_word),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_word      (q_word)
    );

    zsee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_word      (q_word),
        .o_pop         (pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_word        (out_word)
    );

    assign o_kind         = out_word.kind;
    assign o_payload_byte = out_word.payload_byte;
    assign o_last         = out_word.last;
    assign o_error_code   = out_word.err_code;

endmodule

/* design/zsee_checker.sv */
// port-level checker for the stored zip entry extractor, bound to the top level
// depends on zsee_pkg and zip_stored_entry_extractor_unit_macros.svh
`include "zip_stored_entry_extractor_unit_macros.svh"

module zsee_checker import zsee_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_kind,
    input logic [7:0]            o_payload_byte,
    input logic                  o_last,
    input logic [2:0]            o_error_code
);

    `ZSEE_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output word dropped while stalled")
    `ZSEE_ASSERT_NXT(a_out_word_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_kind) && $stable(o_payload_byte) && $stable(o_last) && $stable(o_error_code), "stalled output word changed")
    `ZSEE_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n, o_out_valid && o_kind == KIND_ERROR, o_last && o_payload_byte == 8'h00, "error word without last or with data")
    `ZSEE_ASSERT_IMP(a_data_no_code, i_clk, i_rst_n, o_out_valid && o_kind == KIND_DATA, o_error_code == ERR_SIGNATURE, "payload word carries an error code")

endmodule

bind zip_stored_entry_extractor_unit zsee_checker u_zsee_checker (.*);
